// ----- rtl/core/ksd_pkg.sv -----
`default_nettype none
package ksd_pkg;

	localparam int EXP_TABLE_DEPTH = 256;
	localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);
	localparam int XQ_BITS = 21;
	localparam logic [16:0] LOG2E_Q16 = 17'd94548;
	localparam logic [63:0] LN2_Q30 = 64'd744261118;
	localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
	// Reciprocal of 15625 scaled by 2^53 and rounded up; exact for every 39-bit dividend.
	localparam logic [39:0] DELTA_RECIP = 40'd576460752304;
	localparam logic [44:0] DELTA_SAT = 45'd33554432000000;
	localparam logic [25:0] DELTA_POS_MAX = 26'h1FF_FFFF;
	localparam logic [25:0] DELTA_NEG_MAG = 26'h200_0000;
	localparam logic REG_STOP = 1'b0;

	typedef logic [30:0] exp_tab_t [EXP_TABLE_DEPTH];

	typedef struct packed {
		logic        vld;
		logic        zero;
		logic        neg;
		logic        big;
		logic [23:0] mag;
		logic [21:0] tau;
		logic [21:0] rem;
		logic [20:0] lo;
		logic [20:0] quo;
	} xdiv_t;

	function automatic logic [63:0] div_k(input logic [63:0] v, input int k);
		case (k)
			2: return v / 2;    3: return v / 3;    4: return v / 4;    5: return v / 5;
			6: return v / 6;    7: return v / 7;    8: return v / 8;    9: return v / 9;
			10: return v / 10;  11: return v / 11;  12: return v / 12;  13: return v / 13;
			14: return v / 14;  15: return v / 15;  16: return v / 16;  17: return v / 17;
			18: return v / 18;  19: return v / 19;  20: return v / 20;
			default: return v;
		endcase
	endfunction

	function automatic exp_tab_t build_tab();
		exp_tab_t tab;
		logic [63:0] t;
		logic [63:0] term;
		logic signed [63:0] sum;
		for (int i = 0; i < EXP_TABLE_DEPTH; i++) begin
			t = (64'(i) * LN2_Q30) / EXP_TABLE_DEPTH;
			term = 64'(ONE_Q30);
			sum = 64'(ONE_Q30);
			for (int k = 1; k <= 20; k++) begin
				term = div_k((term * t) >> 30, k);
				if (k % 2 == 1) begin
					sum = sum - $signed(term);
				end else begin
					sum = sum + $signed(term);
				end
			end
			tab[i] = sum[30:0];
		end
		return tab;
	endfunction

	localparam exp_tab_t EXP_TAB = build_tab();

endpackage
`default_nettype wire

// ----- rtl/core/kinetic_scroll_decay_step.sv -----
`default_nettype none
// One momentum-scroll tick per transfer: decay = exp(-elapsed/tau), scroll delta and next
// velocity, in a fixed pipeline of 31 register stages that takes a new transfer every cycle
// unless the result side stalls; the depth is set mostly by the one-bit-per-stage divider
// for elapsed/tau (21 stages), while the division of the delta by 10^6 is a reciprocal
// multiplication over three stages. A stall on the result side holds the whole pipeline.
// s_tdata holds speed_now[23:0], decay_time_us[45:24], elapsed_us[65:46]; m_tdata holds
// scroll_delta[25:0], speed_next[49:26], done_res[50]. The stop threshold lies at byte
// address 0.
module kinetic_scroll_decay_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [71:0] s_tdata,   // speed_now, decay_time_us, elapsed_us, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // scroll_delta, speed_next, done_res, zero pad
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	import ksd_pkg::*;

	logic [22:0] stop_q;
	logic        adv;
	logic [23:0] v_in;
	logic [21:0] tau_in;
	logic [19:0] el_in;
	logic [23:0] mag_in;

	xdiv_t xd_s [0:XQ_BITS];

	logic        vld_s1, zero_s1, neg_s1, big_s1;
	logic [23:0] mag_s1;
	logic [37:0] yp_s1;
	logic [45:0] mt_s1;

	logic            vld_s2, zero_s2, neg_s2, dz_s2;
	logic [23:0]     mag_s2;
	logic [45:0]     mt_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [4:0]      sh_s2;

	logic        vld_s3, zero_s3, neg_s3;
	logic [23:0] mag_s3;
	logic [45:0] mt_s3;
	logic [30:0] decay_s3;

	logic        vld_s4, zero_s4, neg_s4;
	logic [54:0] nmp_s4;
	logic [18:0] om_s4;
	logic [45:0] mt_s4;

	logic        vld_s5, zero_s5, neg_s5, done_s5;
	logic [23:0] nm_s5;
	logic [41:0] pa_s5, pb_s5;

	logic        vld_s6, zero_s6, neg_s6, done_s6, sat_s6;
	logic [23:0] nm_s6;
	logic [38:0] qa_s6;

	logic        vld_s7, zero_s7, neg_s7, done_s7, sat_s7;
	logic [23:0] nm_s7;
	logic [38:0] p11_s7, p10_s7;
	logic [39:0] p01_s7, p00_s7;

	logic        vld_s8, zero_s8, neg_s8, done_s8, sat_s8;
	logic [23:0] nm_s8;
	logic [24:0] q_s8;

	logic [21:0] y2;
	logic [31:0] fd2;
	logic [15:0] fi2;
	logic [63:0] p6;
	logic [44:0] d6;
	logic [79:0] rq8;

	logic [25:0] dmag;
	logic [25:0] delta_o;
	logic [23:0] speed_o;
	logic        m_vld_q;
	logic [50:0] m_data_q;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_STOP) ? {9'd0, stop_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_q <= 23'd256;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_STOP) begin
			stop_q <= pwdata[22:0];
		end
	end

	assign adv = !m_vld_q || m_tready;
	assign s_tready = adv;

	assign v_in = s_tdata[23:0];
	assign tau_in = s_tdata[45:24];
	assign el_in = s_tdata[65:46];
	assign mag_in = v_in[23] ? (~v_in + 24'd1) : v_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			xd_s[0] <= '0;
		end else if (adv) begin
			xd_s[0].vld <= s_tvalid;
			xd_s[0].zero <= (tau_in == 22'd0) || (el_in == 20'd0) || (mag_in <= {1'b0, stop_q});
			xd_s[0].neg <= v_in[23];
			xd_s[0].big <= {7'd0, el_in} >= {tau_in, 5'd0};
			xd_s[0].mag <= mag_in;
			xd_s[0].tau <= tau_in;
			xd_s[0].rem <= {7'd0, el_in[19:5]};
			xd_s[0].lo <= {el_in[4:0], 16'd0};
			xd_s[0].quo <= '0;
		end
	end

	for (genvar k = 0; k < XQ_BITS; k++) begin : g_xdiv
		logic [22:0] t;
		logic        ge;
		xdiv_t       nx;
		always_comb begin
			nx = xd_s[k];
			t = {xd_s[k].rem, xd_s[k].lo[20]};
			ge = t >= {1'b0, xd_s[k].tau};
			nx.rem = ge ? 22'(t - {1'b0, xd_s[k].tau}) : t[21:0];
			nx.lo = {xd_s[k].lo[19:0], 1'b0};
			nx.quo = {xd_s[k].quo[19:0], ge};
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				xd_s[k+1] <= '0;
			end else if (adv) begin
				xd_s[k+1] <= nx;
			end
		end
	end

	always_comb begin
		y2 = yp_s1[37:16];
		fd2 = 32'(y2[15:0]) * 32'(EXP_TABLE_DEPTH);
		fi2 = fd2[31:16];
		if (fi2 > 16'(EXP_TABLE_DEPTH - 1)) begin
			fi2 = 16'(EXP_TABLE_DEPTH - 1);
		end
		p6 = ({22'd0, pa_s5} << 23) + {22'd0, pb_s5};
		d6 = p6[62:18];
		rq8 = (80'(p11_s7) << 40) + (80'(p10_s7) << 20) + (80'(p01_s7) << 20)
			+ 80'(p00_s7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= xd_s[XQ_BITS].vld;
			zero_s1 <= xd_s[XQ_BITS].zero;
			neg_s1 <= xd_s[XQ_BITS].neg;
			big_s1 <= xd_s[XQ_BITS].big;
			mag_s1 <= xd_s[XQ_BITS].mag;
			yp_s1 <= 38'(xd_s[XQ_BITS].quo) * 38'(LOG2E_Q16);
			mt_s1 <= 46'(xd_s[XQ_BITS].mag) * 46'(xd_s[XQ_BITS].tau);

			vld_s2 <= vld_s1;
			zero_s2 <= zero_s1;
			neg_s2 <= neg_s1;
			mag_s2 <= mag_s1;
			mt_s2 <= mt_s1;
			dz_s2 <= big_s1 || (y2[21:16] >= 6'd31);
			idx_s2 <= fi2[IDX_W-1:0];
			sh_s2 <= y2[20:16];

			vld_s3 <= vld_s2;
			zero_s3 <= zero_s2;
			neg_s3 <= neg_s2;
			mag_s3 <= mag_s2;
			mt_s3 <= mt_s2;
			decay_s3 <= dz_s2 ? 31'd0 : (EXP_TAB[idx_s2] >> sh_s2);

			vld_s4 <= vld_s3;
			zero_s4 <= zero_s3;
			neg_s4 <= neg_s3;
			mt_s4 <= mt_s3;
			nmp_s4 <= 55'(mag_s3) * 55'(decay_s3);
			om_s4 <= 19'((ONE_Q30 - decay_s3) >> 12);

			vld_s5 <= vld_s4;
			zero_s5 <= zero_s4;
			neg_s5 <= neg_s4;
			nm_s5 <= nmp_s4[53:30];
			done_s5 <= nmp_s4[53:30] <= {1'b0, stop_q};
			pa_s5 <= 42'(mt_s4[45:23]) * 42'(om_s4);
			pb_s5 <= 42'(mt_s4[22:0]) * 42'(om_s4);

			vld_s6 <= vld_s5;
			zero_s6 <= zero_s5;
			neg_s6 <= neg_s5;
			done_s6 <= done_s5;
			nm_s6 <= nm_s5;
			sat_s6 <= d6 >= DELTA_SAT;
			qa_s6 <= d6[44:6];

			vld_s7 <= vld_s6;
			zero_s7 <= zero_s6;
			neg_s7 <= neg_s6;
			done_s7 <= done_s6;
			nm_s7 <= nm_s6;
			sat_s7 <= sat_s6;
			p11_s7 <= 39'(qa_s6[38:20]) * 39'(DELTA_RECIP[39:20]);
			p10_s7 <= 39'(qa_s6[38:20]) * 39'(DELTA_RECIP[19:0]);
			p01_s7 <= 40'(qa_s6[19:0]) * 40'(DELTA_RECIP[39:20]);
			p00_s7 <= 40'(qa_s6[19:0]) * 40'(DELTA_RECIP[19:0]);

			vld_s8 <= vld_s7;
			zero_s8 <= zero_s7;
			neg_s8 <= neg_s7;
			done_s8 <= done_s7;
			nm_s8 <= nm_s7;
			sat_s8 <= sat_s7;
			q_s8 <= rq8[77:53];
		end
	end

	always_comb begin
		if (sat_s8) begin
			dmag = neg_s8 ? DELTA_NEG_MAG : DELTA_POS_MAX;
		end else begin
			dmag = {1'b0, q_s8};
		end
		delta_o = neg_s8 ? (~dmag + 26'd1) : dmag;
		if (done_s8) begin
			speed_o = 24'd0;
		end else begin
			speed_o = neg_s8 ? (~nm_s8 + 24'd1) : nm_s8;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_vld_q <= 1'b0;
		end else if (adv) begin
			m_vld_q <= vld_s8;
			if (zero_s8) begin
				m_data_q <= '0;
			end else begin
				m_data_q <= {done_s8, speed_o, delta_o};
			end
		end
	end

	assign m_tvalid = m_vld_q;
	assign m_tdata = {5'd0, m_data_q};

endmodule
`default_nettype wire

// ----- rtl/core/ksd_checker.sv -----
`default_nettype none
module ksd_port_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [55:0] m_tdata
);

	// A stalled result transfer holds its data.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// The input side is ready whenever the result register can move.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the result side");

	// A finished tick reports zero velocity.
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[50] |-> m_tdata[49:26] == 24'd0)
		else $error("velocity not zero on finish");

	// Zero velocity without finish only comes from a cleared result, so no delta.
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[50] && m_tdata[49:26] == 24'd0 |-> m_tdata[25:0] == 26'd0)
		else $error("delta on an invalid input");

	// Padding bits stay clear.
	a_pad: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[55:51] == 5'd0)
		else $error("pad bits set");

endmodule

bind kinetic_scroll_decay_step ksd_port_checker u_ksd_port_checker (
	.clk(clk),
	.arst_n(arst_n),
	.s_tvalid(s_tvalid),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);
`default_nettype wire
